@@ rtl/color_blob_centroid_tracker_top_assert.svh @@
// assertion macros for the color blob centroid tracker
// used by color_blob_centroid_tracker_top, no other dependencies
`ifndef COLOR_BLOB_CENTROID_TRACKER_TOP_ASSERT_SVH
`define COLOR_BLOB_CENTROID_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CBCT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cbct assertion failed");
// next-cycle implication
`define CBCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cbct assertion failed");
`else
`define CBCT_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define CBCT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/cbct_pkg.sv @@
// shared widths, constants and control types of the centroid tracker
// no dependencies
package cbct_pkg;

	localparam int CH_W     = 8;   // one hsv channel
	localparam int HELD_X_W = 10;
	localparam int HELD_Y_W = 9;
	localparam int HIT_W    = 19;
	localparam int SUM_W    = 28;
	localparam int MX_W     = 11;  // mirrored x before masking, holds up to 2047
	localparam int CX_W     = 11;
	localparam int CY_W     = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MAX = 3'd5;

	localparam logic [CH_W-1:0] HUE_MIN_RST = 8'd10;
	localparam logic [CH_W-1:0] HUE_MAX_RST = 8'd20;
	localparam logic [CH_W-1:0] SAT_MIN_RST = 8'd124;
	localparam logic [CH_W-1:0] SAT_MAX_RST = 8'd140;
	localparam logic [CH_W-1:0] VAL_MIN_RST = 8'd140;
	localparam logic [CH_W-1:0] VAL_MAX_RST = 8'd146;

	localparam logic [HELD_X_W-1:0] HELD_X_RST = 10'd100;
	localparam logic [HELD_Y_W-1:0] HELD_Y_RST = 9'd100;

	// dead-zone edges
	localparam logic [MX_W-1:0]     LEFT_EDGE   = 11'd250;
	localparam logic [MX_W-1:0]     RIGHT_EDGE  = 11'd390;
	localparam logic [HELD_Y_W-1:0] TOP_EDGE    = 9'd190;
	localparam logic [HELD_Y_W-1:0] BOTTOM_EDGE = 9'd270;

	// y*166/100 as y * (166 * ceil(2^24/100)) >> 24, exact for 9-bit y
	localparam int CY_MUL_W = 25;
	localparam int CY_SHIFT = 24;
	localparam int CY_PROD_W = HELD_Y_W + CY_MUL_W;
	localparam logic [CY_MUL_W-1:0] CURSOR_Y_MUL = 25'd27850318;

	typedef struct packed {
		logic pixel_en;    // pixel transaction this cycle
		logic div_start;   // load dividers, clear accumulators
		logic update_held; // take quotients into held position
		logic load_out;    // fill output register
	} cbct_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} cbct_status_t;

endpackage

@@ rtl/color_blob_centroid_tracker_top.sv @@
// top level of the color blob centroid tracker
// depends on cbct_pkg, cbct_ctrl, cbct_datapath and the assertion macro header
//
// usage
// - s_axis carries one hsv pixel per transaction in raster order, starting at
//   column 0, row 0; tlast marks the last pixel of a frame
// - pixels are taken one per cycle outside the frame-end sequence; a pixel is
//   selected when hue, saturation and brightness all lie inside their inclusive bounds
// - on the tlast pixel the column and row sums are divided by the hit count in
//   two 28-step serial dividers, the held centroid is updated and one result
//   transaction goes out on m_axis
// - after the tlast transaction s_axis_tready stays low while the dividers run,
//   the held centroid is updated and the result is loaded; m_axis_tvalid rises
//   once the result is loaded
// - the output register decouples the sides: pixels of the next frame are taken
//   while a result waits; after the next tlast pixel intake stays stopped until it is taken
// - cfg carries register writes (index 0..5: hue, sat, val min/max), always
//   ready; write only while no frame result is in flight
// - reset restores default bounds, clears accumulators and raster position,
//   sets the held centroid to (100, 100) and empties the output register
`include "color_blob_centroid_tracker_top_assert.svh"

module color_blob_centroid_tracker_top import cbct_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // hue[7:0], saturation[15:8], brightness[23:16]
	input  logic                  s_axis_tlast,  // frame_end
	// centroid result
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // mirrored_x[9:0], centroid_y[18:10],
	                                             // cursor_x[29:19], cursor_y[39:30],
	                                             // go_left[40], go_right[41], go_up[42],
	                                             // go_down[43], zero[47:44]
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CH_W-1:0]       cfg_data
);

	cbct_cmd_t    cmd;
	cbct_status_t status;

	// config writes go straight into the config registers, so the channel is always ready
	assign cfg_ready = 1'b1;

	cbct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cbct_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.hue        (s_axis_tdata[7:0]),
		.saturation (s_axis_tdata[15:8]),
		.brightness (s_axis_tdata[23:16]),
		.frame_end  (s_axis_tlast),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_data   (m_axis_tdata)
	);

	// a result is never loaded over one that has not been taken
	`CBCT_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.load_out, status.out_free)
	// the frame-end transaction stops pixel intake for the division
	`CBCT_ASSERT_NEXT(a_stop_at_frame_end, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
	// dividers finish only while intake is stopped
	`CBCT_ASSERT_IMPL(a_div_while_stopped, clk, arst_n, status.div_done, !s_axis_tready)
	// a load shows up on the result channel next cycle
	`CBCT_ASSERT_NEXT(a_load_visible, clk, arst_n, cmd.load_out, m_axis_tvalid)

endmodule

@@ rtl/cbct_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on cbct_pkg
module cbct_div import cbct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [HIT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dq_q;   // dividend shifts out, quotient shifts in
	logic [HIT_W-1:0] dsr_q;
	logic [HIT_W-1:0] rem_q;
	logic [HIT_W:0]   trial;
	logic [HIT_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[HIT_W-1:0] : trial[HIT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ rtl/cbct_ctrl.sv @@
// frame sequencer: pixel accumulation, division, held update, result load
// depends on cbct_pkg
module cbct_ctrl import cbct_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_last,
	output logic         in_ready,
	input  cbct_status_t status,
	output cbct_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					if (in_valid && in_last) state_q <= ST_START;
				end
				ST_START:  state_q <= ST_DIVIDE;
				ST_DIVIDE: begin
					if (status.div_done) state_q <= ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (status.out_free) state_q <= ST_ACCUM;
				end
				default: state_q <= ST_ACCUM;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_ACCUM);
	assign cmd.pixel_en    = (state_q == ST_ACCUM) && in_valid;
	assign cmd.div_start   = (state_q == ST_START);
	assign cmd.update_held = (state_q == ST_UPDATE);
	assign cmd.load_out    = (state_q == ST_EMIT) && status.out_free;

endmodule

@@ rtl/cbct_datapath.sv @@
// thresholds, raster position, accumulators, dividers, held position, output register
// depends on cbct_pkg and cbct_div
module cbct_datapath import cbct_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbct_cmd_t             cmd,
	output cbct_status_t          status,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CH_W-1:0]       cfg_data,
	input  logic [CH_W-1:0]       hue,
	input  logic [CH_W-1:0]       saturation,
	input  logic [CH_W-1:0]       brightness,
	input  logic                  frame_end,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
	localparam logic [MX_W-1:0]  FW_MX    = MX_W'(FRAME_WIDTH);
	localparam int PAD_W = OUT_DATA_W - (HELD_X_W + HELD_Y_W + CX_W + CY_W + 4);

	logic [CH_W-1:0] hue_min_q, hue_max_q, sat_min_q, sat_max_q, val_min_q, val_max_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [HIT_W-1:0] hit_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [HELD_X_W-1:0] held_x_q;
	logic [HELD_Y_W-1:0] held_y_q;
	logic hit_nz_q;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic selected;
	logic [SUM_W:0] sx_next, sy_next;
	logic div_done_x, div_done_y;
	logic [SUM_W-1:0] qx, qy;
	logic [MX_W-1:0] mx;
	logic [CY_PROD_W-1:0] cy_prod;
	logic [CX_W-1:0] cursor_x;
	logic [CY_W-1:0] cursor_y;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_min_q <= HUE_MIN_RST;
			hue_max_q <= HUE_MAX_RST;
			sat_min_q <= SAT_MIN_RST;
			sat_max_q <= SAT_MAX_RST;
			val_min_q <= VAL_MIN_RST;
			val_max_q <= VAL_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HUE_MIN: hue_min_q <= cfg_data;
				REG_HUE_MAX: hue_max_q <= cfg_data;
				REG_SAT_MIN: sat_min_q <= cfg_data;
				REG_SAT_MAX: sat_max_q <= cfg_data;
				REG_VAL_MIN: val_min_q <= cfg_data;
				REG_VAL_MAX: val_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign selected = (hue >= hue_min_q) && (hue <= hue_max_q) &&
	                  (saturation >= sat_min_q) && (saturation <= sat_max_q) &&
	                  (brightness >= val_min_q) && (brightness <= val_max_q);

	assign sx_next = {1'b0, sum_x_q} + (SUM_W + 1)'(col_q);
	assign sy_next = {1'b0, sum_y_q} + (SUM_W + 1)'(row_q);

	// raster position and saturating accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			hit_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.div_start) begin
			hit_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.pixel_en) begin
			if (selected) begin
				if (hit_q != '1) hit_q <= hit_q + 1'b1;
				sum_x_q <= sx_next[SUM_W] ? '1 : sx_next[SUM_W-1:0];
				sum_y_q <= sy_next[SUM_W] ? '1 : sy_next[SUM_W-1:0];
			end
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == COL_LAST) begin
				col_q <= '0;
				row_q <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	cbct_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_x_q),
		.divisor  (hit_q),
		.done     (div_done_x),
		.quotient (qx)
	);

	cbct_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_y_q),
		.divisor  (hit_q),
		.done     (div_done_y),
		.quotient (qy)
	);

	// held position keeps its value on an empty frame or a zero quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_nz_q <= 1'b0;
			held_x_q <= HELD_X_RST;
			held_y_q <= HELD_Y_RST;
		end else begin
			if (cmd.div_start) hit_nz_q <= (hit_q != '0);
			if (cmd.update_held && hit_nz_q) begin
				if (qx != '0) held_x_q <= qx[HELD_X_W-1:0];
				if (qy != '0) held_y_q <= qy[HELD_Y_W-1:0];
			end
		end
	end

	assign mx       = ({1'b0, held_x_q} > FW_MX) ? '0 : FW_MX - MX_W'(held_x_q);
	assign cursor_x = {mx[HELD_X_W-1:0], 1'b0};
	assign cy_prod  = CY_PROD_W'(held_y_q) * CY_PROD_W'(CURSOR_Y_MUL);
	assign cursor_y = cy_prod[CY_SHIFT +: CY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {{PAD_W{1'b0}},
			               (held_y_q > BOTTOM_EDGE),
			               (held_y_q < TOP_EDGE),
			               (mx > RIGHT_EDGE),
			               (mx < LEFT_EDGE),
			               cursor_y,
			               cursor_x,
			               held_y_q,
			               mx[HELD_X_W-1:0]};
		end
	end

	assign status.div_done = div_done_x && div_done_y;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule
